// ===== hw/rtl/arpc_pkg.sv =====
`timescale 1ns / 1ps
// arpc_pkg: shared types, sizes and the replacement lfsr step for the arp cache table
// no dependencies; imported by arpc_victim and arp_cache_table

package arpc_pkg;

   // table size, kept a power of two so the random victim is a plain mask
   localparam int ENTRY_BITS = 5;
   localparam int ENTRIES    = 1 << ENTRY_BITS;

   localparam logic [15:0] LFSR_RESET    = 16'hACE1;
   localparam logic [7:0]  TIMEOUT_RESET = 8'd15;
   localparam logic [7:0]  AGE_MAX       = 8'hFF;

   typedef enum logic [1:0] {
      CMD_LOOKUP  = 2'd0,
      CMD_INSERT  = 2'd1,
      CMD_REFRESH = 2'd2,
      CMD_TICK    = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type     command;
      logic [31:0] ip_address;
      logic [47:0] mac_address;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic [47:0] found_mac;
      logic [4:0]  slot;
   } rsp_type;

   // one table entry as stored in the entry memory
   typedef struct packed {
      logic [31:0] ip;
      logic [47:0] mac;
      logic [7:0]  age;
   } entry_type;

   // insert target chosen from the valid bits or the lfsr
   typedef struct packed {
      logic                  full;
      logic [ENTRY_BITS-1:0] idx;
   } victim_type;

   // fibonacci lfsr, taps 16,14,13,11
   function automatic logic [15:0] lfsr_next(input logic [15:0] s);
      logic fb;
      fb = s[0] ^ s[2] ^ s[3] ^ s[5];
      return {fb, s[15:1]};
   endfunction

endpackage

// ===== hw/rtl/arpc_victim.sv =====
`timescale 1ns / 1ps
// arpc_victim: picks the slot an insert writes, first free entry or lfsr choice
// depends on arpc_pkg

module arpc_victim
   import arpc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [ENTRIES-1:0] valid_vec,
   input  logic               take,
   output victim_type         victim
);

   logic [15:0]           lfsr_ff;
   logic [15:0]           lfsr_step;
   logic                  free_found;
   logic [ENTRY_BITS-1:0] free_idx;

   // lowest numbered invalid entry
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!valid_vec[i]) begin
            free_found = 1'b1;
            free_idx   = ENTRY_BITS'(i);
         end
      end
   end

   assign lfsr_step   = lfsr_next(lfsr_ff);
   assign victim.full = !free_found;
   assign victim.idx  = free_found ? free_idx : lfsr_step[ENTRY_BITS-1:0];

   // lfsr only moves when a full table forces a random replacement
   always_ff @(posedge clock) begin
      if (reset) begin
         lfsr_ff <= LFSR_RESET;
      end else if (take && victim.full) begin
         lfsr_ff <= lfsr_step;
      end
   end

endmodule

// ===== hw/rtl/arp_cache_table.sv =====
`timescale 1ns / 1ps
// arp_cache_table: one transaction in, one transaction out per command
// lookup, refresh and tick walk the entry memory one entry per cycle; a lookup hit stops
// the walk early; insert skips the walk and writes the chosen slot directly
// the single-port read of the entry memory sets the scan rate
// synchronous reset clears valid bits and handshakes and reloads lfsr and timeout; memory is not cleared
// depends on arpc_pkg and arpc_victim

module arp_cache_table
   import arpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // command transactions
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   // result transactions
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   // timeout register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_INSERT,
      ST_FIN
   } state_type;

   state_type             state_ff;
   req_type               cmd_ff;
   rsp_type               res_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff;
   logic [7:0]            timeout_ff;
   logic [ENTRIES-1:0]    valid_ff;

   // scan pipeline: issue counter, then in the next cycle the checked entry
   logic [ENTRY_BITS:0]   issue_ff;
   logic                  chk_vld_ff;
   logic [ENTRY_BITS-1:0] chk_idx_ff;

   // entry memory, one write and one registered read per cycle
   entry_type             entry_mem [ENTRIES];
   entry_type             rd_data_ff;
   logic                  rd_go;
   logic [ENTRY_BITS-1:0] rd_addr;
   logic                  mem_we;
   logic [ENTRY_BITS-1:0] mem_waddr;
   entry_type             mem_wdata;

   logic                  req_take;
   logic                  chk_live;
   logic                  match;
   logic [7:0]            age_inc;
   logic                  expire;
   logic                  scan_end;
   logic                  out_free;
   victim_type            victim;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // read side of the scan: next entry while the counter has not run past the end
   assign rd_go   = (state_ff == ST_SCAN) && !issue_ff[ENTRY_BITS];
   assign rd_addr = issue_ff[ENTRY_BITS-1:0];

   // the entry read last cycle, only meaningful when it is valid
   assign chk_live = chk_vld_ff && valid_ff[chk_idx_ff];
   assign match    = chk_live && (rd_data_ff.ip == cmd_ff.ip_address);
   assign age_inc  = (rd_data_ff.age == AGE_MAX) ? AGE_MAX : rd_data_ff.age + 8'd1;
   assign expire   = age_inc > timeout_ff;
   assign scan_end = chk_vld_ff && (chk_idx_ff == ENTRY_BITS'(ENTRIES - 1));
   assign out_free = !rsp_valid_ff || rsp_ready;

   // write-back: insert, refresh on match, age update on tick
   // each entry is read once and written at most once per scan, so no forwarding is needed
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = chk_idx_ff;
      mem_wdata = rd_data_ff;
      if (state_ff == ST_INSERT) begin
         mem_we    = 1'b1;
         mem_waddr = victim.idx;
         mem_wdata = '{ip: cmd_ff.ip_address, mac: cmd_ff.mac_address, age: 8'd0};
      end else if (state_ff == ST_SCAN) begin
         if (cmd_ff.command == CMD_REFRESH && match) begin
            mem_we        = 1'b1;
            mem_wdata.mac = cmd_ff.mac_address;
            mem_wdata.age = 8'd0;
         end else if (cmd_ff.command == CMD_TICK && chk_live) begin
            mem_we        = 1'b1;
            mem_wdata.age = age_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_waddr] <= mem_wdata;
      end
      if (rd_go) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

   // insert slot selection and replacement lfsr
   arpc_victim u_victim (
      .clock     (clock),
      .reset     (reset),
      .valid_vec (valid_ff),
      .take      (state_ff == ST_INSERT),
      .victim    (victim)
   );

   // timeout register, loaded with the whole 8-bit write
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_valid && csr_ready) begin
         timeout_ff <= csr_data;
      end
   end

   // command sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         issue_ff     <= '0;
         chk_vld_ff   <= 1'b0;
      end else begin
         // result leaves when the consumer takes it, unless the next one replaces it
         if (rsp_valid_ff && rsp_ready && state_ff != ST_FIN) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  cmd_ff     <= req_data;
                  res_ff     <= '0;
                  issue_ff   <= '0;
                  chk_vld_ff <= 1'b0;
                  state_ff   <= (req_data.command == CMD_INSERT) ? ST_INSERT : ST_SCAN;
               end
            end
            ST_SCAN: begin
               issue_ff   <= issue_ff + (ENTRY_BITS + 1)'(rd_go);
               chk_vld_ff <= rd_go;
               chk_idx_ff <= rd_addr;
               // aging may drop the entry just checked
               if (cmd_ff.command == CMD_TICK && chk_live && expire) begin
                  valid_ff[chk_idx_ff] <= 1'b0;
               end
               if (cmd_ff.command == CMD_LOOKUP && match) begin
                  // first match wins, rest of the walk is dropped
                  res_ff.hit       <= 1'b1;
                  res_ff.found_mac <= rd_data_ff.mac;
                  res_ff.slot      <= 5'(chk_idx_ff);
                  state_ff         <= ST_FIN;
               end else if (scan_end) begin
                  state_ff <= ST_FIN;
               end
            end
            ST_INSERT: begin
               valid_ff[victim.idx] <= 1'b1;
               res_ff.slot          <= 5'(victim.idx);
               state_ff             <= ST_FIN;
            end
            ST_FIN: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= res_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // scan write-back only for an entry whose read data is in hand
   a_wb_needs_read: assert property (@(posedge clock) disable iff (reset)
      (mem_we && state_ff == ST_SCAN) |-> chk_vld_ff)
      else $error("scan write-back without a checked entry");

   // a lookup hit ends the walk at once
   a_hit_stops_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && cmd_ff.command == CMD_LOOKUP && match) |=> state_ff == ST_FIN)
      else $error("lookup kept scanning after a hit");

   // an insert always leaves its slot valid
   a_insert_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INSERT) |=> valid_ff[$past(victim.idx)])
      else $error("inserted entry not marked valid");

endmodule
